// File: rtl/pdh_pkg.sv
// shared types and constants for the point density histogram
`default_nettype none

package pdh_pkg;

  // command codes carried by an input beat
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_USED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_USED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE     = 3'd5;

  // field widths
  localparam int COORD_W = 32;
  localparam int SCALE_W = 32;
  localparam int DIM_CFG_W = 10;
  localparam int BIN_IDX_W = 18;
  localparam int OUT_CNT_W = 32;

  // difference magnitude is Q5.28 unsigned, product fraction is 44 bits
  localparam int MAG_W = COORD_W + 1;
  localparam int PROD_W = MAG_W + SCALE_W;
  localparam int FRAC_BITS = 44;
  localparam int WHOLE_W = PROD_W - FRAC_BITS;

  // reset values of the registers
  localparam logic [DIM_CFG_W-1:0] RST_WIDTH_USED  = 10'd512;
  localparam logic [DIM_CFG_W-1:0] RST_HEIGHT_USED = 10'd512;
  localparam logic [COORD_W-1:0]   RST_LEFT_EDGE   = 32'hE000_0000;
  localparam logic [COORD_W-1:0]   RST_TOP_EDGE    = 32'h1800_0000;
  localparam logic [SCALE_W-1:0]   RST_X_SCALE     = 32'd11162965;
  localparam logic [SCALE_W-1:0]   RST_Y_SCALE     = 32'd11162965;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_BIN,
    ST_ADDR,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/pdh_ram.sv
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module pdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/point_density_histogram_unit.sv
// point density histogram: maps plane points to bins and counts them in a ram
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_ready, command, point_x, point_y,  | in
//           | bin_index                                      |
//   result  | out_valid, out_ready, count, hit               | out
//   config  | cfg_write, cfg_index, cfg_data                 | in
//
// from acceptance to a loaded result an add beat steps through multiply, bin, address, ram
// read, read-modify-write and load, skipping ram read and read-modify-write on a miss; a
// read beat steps through ram read, update and load, or only load for an index outside
// the store. one beat is in flight at a time: the next is taken in the idle state after
// the load; a result left waiting holds the next beat in the done state. after reset a
// clearing pass zeroes all MAX_COLUMNS * MAX_ROWS bins, one a cycle, before a beat is taken.
`default_nettype none

module point_density_histogram_unit #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 512,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 command,
  input  wire logic signed [pdh_pkg::COORD_W-1:0]   point_x,
  input  wire logic signed [pdh_pkg::COORD_W-1:0]   point_y,
  input  wire logic [pdh_pkg::BIN_IDX_W-1:0]        bin_index,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [pdh_pkg::OUT_CNT_W-1:0]             count,
  output logic                                      hit,
  // configuration port
  input  wire logic                                 cfg_write,
  input  wire logic [pdh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pdh_pkg::COORD_W-1:0]          cfg_data
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW = $clog2(MAX_COLUMNS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int IDX_W = WW + HW;
  localparam int EXT_W = (COUNT_BITS > pdh_pkg::OUT_CNT_W) ? COUNT_BITS : pdh_pkg::OUT_CNT_W;
  localparam int MW = pdh_pkg::MAG_W;
  localparam int PW = pdh_pkg::PROD_W;
  localparam int SW = pdh_pkg::SCALE_W;

  // configuration registers
  logic [pdh_pkg::DIM_CFG_W-1:0] width_used;
  logic [pdh_pkg::DIM_CFG_W-1:0] height_used;
  logic [pdh_pkg::COORD_W-1:0]   left_edge;
  logic [pdh_pkg::COORD_W-1:0]   top_edge;
  logic [SW-1:0]                 x_scale;
  logic [SW-1:0]                 y_scale;

  // sequencer and datapath registers
  pdh_pkg::state_t state;
  pdh_pkg::state_t state_next;
  logic [ADDR_W-1:0]     clear_addr;
  logic                  cmd_read;
  logic                  neg_x;
  logic                  neg_y;
  logic [MW-1:0]         mag_x;
  logic [MW-1:0]         mag_y;
  logic [2*SW-1:0]       prod_x;
  logic [2*SW-1:0]       prod_y;
  logic                  in_map;
  logic [WW-1:0]         col;
  logic [HW-1:0]         row;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;
  logic [ADDR_W-1:0]     addr;
  logic [pdh_pkg::OUT_CNT_W-1:0] res_count;
  logic                  res_hit;

  // ram controls
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [COUNT_BITS-1:0] mem_rdata;

  // combinational helpers
  logic [MW-1:0]         diff_x;
  logic [MW-1:0]         diff_y;
  logic [PW-1:0]         full_x;
  logic [PW-1:0]         full_y;
  logic [pdh_pkg::WHOLE_W-1:0] whole_x;
  logic [pdh_pkg::WHOLE_W-1:0] whole_y;
  logic                  ok_x;
  logic                  ok_y;
  logic                  read_in_range;
  logic [IDX_W-1:0]      bin_sum;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [EXT_W-1:0]      inc_ext;
  logic [EXT_W-1:0]      rd_ext;
  logic                  out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      width_used  <= pdh_pkg::RST_WIDTH_USED;
      height_used <= pdh_pkg::RST_HEIGHT_USED;
      left_edge   <= pdh_pkg::RST_LEFT_EDGE;
      top_edge    <= pdh_pkg::RST_TOP_EDGE;
      x_scale     <= pdh_pkg::RST_X_SCALE;
      y_scale     <= pdh_pkg::RST_Y_SCALE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pdh_pkg::REG_WIDTH_USED:  width_used  <= cfg_data[pdh_pkg::DIM_CFG_W-1:0];
        pdh_pkg::REG_HEIGHT_USED: height_used <= cfg_data[pdh_pkg::DIM_CFG_W-1:0];
        pdh_pkg::REG_LEFT_EDGE:   left_edge   <= cfg_data;
        pdh_pkg::REG_TOP_EDGE:    top_edge    <= cfg_data;
        pdh_pkg::REG_X_SCALE:     x_scale     <= cfg_data;
        pdh_pkg::REG_Y_SCALE:     y_scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  // signed differences, exact in 33 bits
  assign diff_x = {point_x[pdh_pkg::COORD_W-1], point_x}
                - {left_edge[pdh_pkg::COORD_W-1], left_edge};
  assign diff_y = {top_edge[pdh_pkg::COORD_W-1], top_edge}
                - {point_y[pdh_pkg::COORD_W-1], point_y};

  // full product: low 32 magnitude bits times scale, plus scale for the top bit
  assign full_x = {1'b0, prod_x} + (mag_x[MW-1] ? {1'b0, x_scale, {SW{1'b0}}} : '0);
  assign full_y = {1'b0, prod_y} + (mag_y[MW-1] ? {1'b0, y_scale, {SW{1'b0}}} : '0);
  assign whole_x = full_x[PW-1:pdh_pkg::FRAC_BITS];
  assign whole_y = full_y[PW-1:pdh_pkg::FRAC_BITS];
  assign ok_x = !(neg_x && (whole_x != '0));
  assign ok_y = !(neg_y && (whole_y != '0));

  // read index range check and bin address
  assign read_in_range = (32'(bin_index) < 32'(DEPTH));
  assign bin_sum = IDX_W'(row) * IDX_W'(w_eff) + IDX_W'(col);

  // saturating increment and zero-extended result forms
  assign cnt_inc = (mem_rdata == '1) ? mem_rdata : mem_rdata + 1'b1;
  assign inc_ext = EXT_W'(cnt_inc);
  assign rd_ext  = EXT_W'(mem_rdata);

  assign out_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdh_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and ram controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr;
    mem_wdata  = cnt_inc;
    mem_re     = 1'b0;
    unique case (state)
      pdh_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = '0;
        if (clear_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = pdh_pkg::ST_IDLE;
        end
      end
      pdh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == pdh_pkg::CMD_READ) begin
            state_next = read_in_range ? pdh_pkg::ST_READ : pdh_pkg::ST_DONE;
          end else begin
            state_next = pdh_pkg::ST_MUL;
          end
        end
      end
      pdh_pkg::ST_MUL: begin
        state_next = pdh_pkg::ST_BIN;
      end
      pdh_pkg::ST_BIN: begin
        state_next = pdh_pkg::ST_ADDR;
      end
      pdh_pkg::ST_ADDR: begin
        state_next = in_map ? pdh_pkg::ST_READ : pdh_pkg::ST_DONE;
      end
      pdh_pkg::ST_READ: begin
        mem_re     = 1'b1;
        state_next = pdh_pkg::ST_UPDATE;
      end
      pdh_pkg::ST_UPDATE: begin
        mem_we     = (cmd_read == pdh_pkg::CMD_ADD);
        state_next = pdh_pkg::ST_DONE;
      end
      pdh_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = pdh_pkg::ST_IDLE;
        end
      end
      default: state_next = pdh_pkg::ST_IDLE;
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (state == pdh_pkg::ST_CLEAR) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  // datapath: capture, multiply, bin, address, update
  always_ff @(posedge clk) begin
    unique case (state)
      pdh_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_read  <= command;
          neg_x     <= diff_x[MW-1];
          neg_y     <= diff_y[MW-1];
          mag_x     <= diff_x[MW-1] ? (~diff_x + 1'b1) : diff_x;
          mag_y     <= diff_y[MW-1] ? (~diff_y + 1'b1) : diff_y;
          addr      <= ADDR_W'(bin_index);
          res_count <= '0;
          res_hit   <= 1'b0;
          w_eff <= ({22'b0, width_used} < 32'(MAX_COLUMNS)) ? WW'(width_used)
                                                           : WW'(MAX_COLUMNS);
          h_eff <= ({22'b0, height_used} < 32'(MAX_ROWS)) ? HW'(height_used)
                                                         : HW'(MAX_ROWS);
        end
      end
      pdh_pkg::ST_MUL: begin
        prod_x <= (2*SW)'(mag_x[SW-1:0]) * (2*SW)'(x_scale);
        prod_y <= (2*SW)'(mag_y[SW-1:0]) * (2*SW)'(y_scale);
      end
      pdh_pkg::ST_BIN: begin
        in_map <= ok_x && ok_y
               && (whole_x < pdh_pkg::WHOLE_W'(w_eff))
               && (whole_y < pdh_pkg::WHOLE_W'(h_eff));
        col <= WW'(whole_x);
        row <= HW'(whole_y);
      end
      pdh_pkg::ST_ADDR: begin
        addr <= ADDR_W'(bin_sum);
      end
      pdh_pkg::ST_UPDATE: begin
        if (cmd_read == pdh_pkg::CMD_READ) begin
          res_count <= rd_ext[pdh_pkg::OUT_CNT_W-1:0];
        end else begin
          res_count <= inc_ext[pdh_pkg::OUT_CNT_W-1:0];
          res_hit   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pdh_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pdh_pkg::ST_DONE && out_free) begin
      count <= res_count;
      hit   <= res_hit;
    end
  end

  // bin count store
  pdh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

`ifndef ASSERT_OFF
  // one beat in flight: no acceptance in the cycle after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("beat accepted while another is in flight");

  // outside the clearing pass the store is written only for an add that hit
  a_write_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != pdh_pkg::ST_CLEAR) |->
      (cmd_read == pdh_pkg::CMD_ADD && in_map && state == pdh_pkg::ST_UPDATE))
    else $error("bin store written outside an add that hit");

  // a result appears only from the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == pdh_pkg::ST_DONE)
    else $error("result raised outside the done state");
`endif

endmodule

`default_nettype wire
